// ===== design/bship_pkg.sv =====
// ----------------------------------------------------------------------------
// bship_pkg - shared types and constants for the Burning Ship core
// Payload words, configuration record, queue entry, register map and
// fixed-point helpers used by the front end, queue, engine and top level.
// ----------------------------------------------------------------------------
package bship_pkg;

   // Field widths
   localparam int PIX_W    = 10;
   localparam int STEP_W   = 31;
   localparam int WORD_W   = 32;
   localparam int LIMIT_W  = 16;
   localparam int COLOUR_W = 24;
   localparam int CSR_AW   = 5;

   // Defaults for the top-level parameters
   localparam int COORD_RANGE_DEF   = 1024;
   localparam int FRACTION_BITS_DEF = 28;
   localparam int QUEUE_DEPTH       = 2;

   // Register reset values
   localparam logic [STEP_W-1:0]          RST_PIXEL_STEP  = 31'd268435;
   localparam logic signed [WORD_W-1:0]   RST_OFFSET_REAL = -32'sd536870912;
   localparam logic signed [WORD_W-1:0]   RST_OFFSET_IMAG = -32'sd536870912;
   localparam logic [LIMIT_W-1:0]         RST_LIMIT       = 16'd100;
   localparam logic [COLOUR_W-1:0]        RST_COLOUR      = 24'd1315860;
   localparam logic [WORD_W-1:0]          BLACK           = 32'h0000_0000;

   typedef enum logic [2:0] {
      REG_PIXEL_STEP  = 3'd0,
      REG_OFFSET_REAL = 3'd1,
      REG_OFFSET_IMAG = 3'd2,
      REG_ITER_LIMIT  = 3'd3,
      REG_BASE_COLOUR = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_col;
      logic [PIX_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]  out_col;
      logic [PIX_W-1:0]  out_row;
      logic [LIMIT_W-1:0] escape_count;
      logic [WORD_W-1:0] pixel_value;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]        pixel_step;
      logic signed [WORD_W-1:0] offset_real;
      logic signed [WORD_W-1:0] offset_imag;
      logic [LIMIT_W-1:0]       iteration_limit;
      logic [COLOUR_W-1:0]      base_colour;
   } cfg_type;

   // One mapped pixel waiting for the engine
   typedef struct packed {
      logic [PIX_W-1:0]         col;
      logic [PIX_W-1:0]         row;
      logic signed [WORD_W-1:0] cr;
      logic signed [WORD_W-1:0] ci;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Clip a wide signed value to the 32-bit word range
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[WORD_W-1:0];
   endfunction

endpackage

// ===== design/bship_front.sv =====
// ----------------------------------------------------------------------------
// bship_front - pixel intake and plane mapping
// Clamps the pixel indices, multiplies by the step, then adds the origin
// with saturation and pushes the mapped point into the job queue.
// ----------------------------------------------------------------------------
module bship_front #(
   parameter int COORD_RANGE = bship_pkg::COORD_RANGE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bship_pkg::cfg_type                cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bship_pkg::req_type                req_data,
   input  bship_pkg::queue_status_type       queue_status,
   output logic                              push,
   output bship_pkg::job_type                push_data
);

   localparam int unsigned CMAX = COORD_RANGE - 1;
   localparam int PROD_W = bship_pkg::PIX_W + bship_pkg::STEP_W;

   logic                             s1_valid_ff, s1_valid_in;
   logic [bship_pkg::PIX_W-1:0]      col_ff, col_in, row_ff, row_in;
   logic [PROD_W-1:0]                prod_r_ff, prod_r_in, prod_i_ff, prod_i_in;
   logic                             accept;
   logic signed [PROD_W+1:0]         sum_r, sum_i;

   function automatic logic [bship_pkg::PIX_W-1:0] clamp(input logic [bship_pkg::PIX_W-1:0] p);
      if (32'(p) > CMAX) begin
         return bship_pkg::PIX_W'(CMAX);
      end
      return p;
   endfunction

   assign req_stall = s1_valid_ff && queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = s1_valid_ff && !queue_status.full;

   always_comb begin
      col_in      = clamp(req_data.pixel_col);
      row_in      = clamp(req_data.pixel_row);
      prod_r_in   = PROD_W'(col_in) * PROD_W'(cfg.pixel_step);
      prod_i_in   = PROD_W'(row_in) * PROD_W'(cfg.pixel_step);
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   // Add origin and clip
   always_comb begin
      sum_r           = $signed({2'b00, prod_r_ff}) + (PROD_W+2)'(cfg.offset_real);
      sum_i           = $signed({2'b00, prod_i_ff}) + (PROD_W+2)'(cfg.offset_imag);
      push_data.col   = col_ff;
      push_data.row   = row_ff;
      push_data.cr    = bship_pkg::sat32(64'(sum_r));
      push_data.ci    = bship_pkg::sat32(64'(sum_i));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         prod_r_ff <= prod_r_in;
         prod_i_ff <= prod_i_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |=> !$past(req_stall) || !s1_valid_ff || $past(accept))
      else $error("front stage lost or duplicated a pixel");

endmodule

// ===== design/bship_queue.sv =====
// ----------------------------------------------------------------------------
// bship_queue - short job queue between front end and engine
// Register-based FIFO; head entry is read directly.
// ----------------------------------------------------------------------------
module bship_queue #(
   parameter int WIDTH = $bits(bship_pkg::job_type),
   parameter int DEPTH = bship_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              pop_data,
   output bship_pkg::queue_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && status.full) && !(pop && status.empty))
      else $error("queue overrun or underrun");

endmodule

// ===== design/bship_engine.sv =====
// ----------------------------------------------------------------------------
// bship_engine - escape-time iteration engine
// Square step registers the three products of z; check step tests escape
// and forms the next z. Result is held in an output register.
// ----------------------------------------------------------------------------
module bship_engine #(
   parameter int FRACTION_BITS = bship_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bship_pkg::cfg_type            cfg,
   input  bship_pkg::queue_status_type   queue_status,
   input  bship_pkg::job_type            job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bship_pkg::rsp_type            rsp_data
);

   localparam int SQ_W  = 64 - FRACTION_BITS;
   localparam int SUM_W = SQ_W + 2;
   localparam int LW    = bship_pkg::LIMIT_W;
   localparam logic [SQ_W:0] ESC_BOUND = (SQ_W+1)'(4) << FRACTION_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_CHECK, ST_FINISH} state_type;

   state_type                           state_ff, state_in;
   logic                                first_ff, first_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                inside_ff, inside_in;
   logic [bship_pkg::PIX_W-1:0]         col_ff, col_in, row_ff, row_in;
   logic signed [31:0]                  cr_ff, cr_in, ci_ff, ci_in;
   logic [30:0]                         zr_ff, zr_in;
   logic signed [31:0]                  zi_ff, zi_in;
   logic [LW-1:0]                       count_ff, count_in;
   logic [63:0]                         prr_ff, prr_in, pii_ff, pii_in, pri_ff, pri_in;
   bship_pkg::rsp_type                  out_ff, out_in;

   logic [31:0]                         zi_mag;
   logic [SQ_W-1:0]                     sq_r, sq_i;
   logic [SQ_W:0]                       cross_prod, esc_sum;
   logic signed [SUM_W-1:0]             re_sum, im_sum;
   logic signed [31:0]                  re_sat, re_neg, im_sat;
   logic [30:0]                         zr_next;
   logic [LW-1:0]                       limit_eff, cnt_next;
   logic [39:0]                         colour_prod;
   logic                                out_free, escaped;

   assign limit_eff = (cfg.iteration_limit == '0) ? LW'(1) : cfg.iteration_limit;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Datapath of one iteration
   always_comb begin
      zi_mag      = zi_ff[31] ? 32'(-zi_ff) : 32'(zi_ff);
      sq_r        = prr_ff[63:FRACTION_BITS];
      sq_i        = pii_ff[63:FRACTION_BITS];
      cross_prod  = pri_ff[63:FRACTION_BITS-1];
      esc_sum     = {1'b0, sq_r} + {1'b0, sq_i};
      escaped     = !first_ff && (esc_sum >= ESC_BOUND);
      re_sum      = $signed({2'b00, sq_r}) - $signed({2'b00, sq_i}) + SUM_W'(cr_ff);
      im_sum      = $signed({1'b0, cross_prod}) + SUM_W'(ci_ff);
      re_sat      = bship_pkg::sat32(64'(re_sum));
      im_sat      = bship_pkg::sat32(64'(im_sum));
      re_neg      = -re_sat;
      if (re_sat == 32'sh8000_0000) begin
         zr_next = 31'h7fff_ffff;
      end else if (re_sat[31]) begin
         zr_next = re_neg[30:0];
      end else begin
         zr_next = re_sat[30:0];
      end
      cnt_next    = first_ff ? count_ff : count_ff + LW'(1);
      colour_prod = 40'(cfg.base_colour) * 40'(count_ff);
   end

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      inside_in    = inside_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      prr_in       = 64'(zr_ff) * 64'(zr_ff);
      pii_in       = 64'(zi_mag) * 64'(zi_mag);
      pri_in       = 64'(zr_ff) * 64'(zi_mag);
      out_in       = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               col_in   = job.col;
               row_in   = job.row;
               cr_in    = job.cr;
               ci_in    = job.ci;
               zr_in    = '0;
               zi_in    = '0;
               count_in = LW'(1);
               first_in = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (escaped) begin
               inside_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (cnt_next >= limit_eff) begin
               count_in  = cnt_next;
               inside_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               count_in  = cnt_next;
               zr_in     = zr_next;
               zi_in     = im_sat;
               first_in  = 1'b0;
               state_in  = ST_SQUARE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_in.out_col      = col_ff;
               out_in.out_row      = row_ff;
               out_in.escape_count = count_ff;
               out_in.pixel_value  = inside_ff ? bship_pkg::BLACK : colour_prod[31:0];
               out_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      count_ff  <= count_in;
      prr_ff    <= prr_in;
      pii_ff    <= pii_in;
      pri_ff    <= pri_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> count_ff != '0 && count_ff <= limit_eff)
      else $error("iteration count outside its range");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.pixel_value != bship_pkg::BLACK
         |-> out_ff.escape_count < limit_eff)
      else $error("colored result with a count at the limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

endmodule

// ===== design/burning_ship_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// burning_ship_escape_time_core - Burning Ship fractal pixel evaluator
// Maps a pixel to the complex plane and returns its escape count and color.
// ----------------------------------------------------------------------------
// Each accepted pixel word (column, row) yields exactly one result word, in
// order. The front end clamps both indices to COORD_RANGE-1, maps the pixel
// to c = index * pixel_step + offset (saturated Q4.28, FRACTION_BITS fraction
// bits), registering the products before the add, and parks it in a
// two-entry queue, so new pixels keep flowing in while the engine is busy.
// The engine iterates z = (|Re z| + i|Im z|)^2 + c from z = 0 through one
// shared set of three 32x32 multipliers; each iteration runs a square step,
// then an update and escape test. A pixel is pulled from the queue before
// its first iteration and loaded into the output register after its last.
// Inside pixels report count = limit and black; escaped pixels report the
// count and base_colour * count modulo 2^32. A limit of zero acts as one.
// The result sits in an output register; a stalled consumer holds the
// engine once that register is full, and the input stalls once the queue
// and the front stage have filled behind it. Registers sit at byte
// addresses 0x00 step, 0x04 real origin, 0x08 imaginary origin, 0x0C
// iteration limit, 0x10 base color; write them only while no pixel is
// in flight.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_core #(
   parameter int COORD_RANGE   = bship_pkg::COORD_RANGE_DEF,
   parameter int FRACTION_BITS = bship_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bship_pkg::req_type            req_data,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bship_pkg::rsp_type            rsp_data,
   // Register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bship_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   bship_pkg::cfg_type             cfg_ff, cfg_in;
   bship_pkg::reg_index_type       csr_index;
   bship_pkg::queue_status_type    queue_status;
   bship_pkg::job_type             push_data, pop_data;
   logic                           push, pop, csr_write;
   logic [$bits(bship_pkg::job_type)-1:0] pop_bits;

   // ---------------------------------------------------------------------
   // Register file: write on the access phase, read back combinationally
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = bship_pkg::reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            bship_pkg::REG_PIXEL_STEP:  cfg_in.pixel_step      = csr_pwdata[30:0];
            bship_pkg::REG_OFFSET_REAL: cfg_in.offset_real     = csr_pwdata;
            bship_pkg::REG_OFFSET_IMAG: cfg_in.offset_imag     = csr_pwdata;
            bship_pkg::REG_ITER_LIMIT:  cfg_in.iteration_limit = csr_pwdata[15:0];
            bship_pkg::REG_BASE_COLOUR: cfg_in.base_colour     = csr_pwdata[23:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bship_pkg::REG_PIXEL_STEP:  csr_prdata = {1'b0, cfg_ff.pixel_step};
         bship_pkg::REG_OFFSET_REAL: csr_prdata = cfg_ff.offset_real;
         bship_pkg::REG_OFFSET_IMAG: csr_prdata = cfg_ff.offset_imag;
         bship_pkg::REG_ITER_LIMIT:  csr_prdata = {16'h0, cfg_ff.iteration_limit};
         bship_pkg::REG_BASE_COLOUR: csr_prdata = {8'h0, cfg_ff.base_colour};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_step      <= bship_pkg::RST_PIXEL_STEP;
         cfg_ff.offset_real     <= bship_pkg::RST_OFFSET_REAL;
         cfg_ff.offset_imag     <= bship_pkg::RST_OFFSET_IMAG;
         cfg_ff.iteration_limit <= bship_pkg::RST_LIMIT;
         cfg_ff.base_colour     <= bship_pkg::RST_COLOUR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front end: clamp, map to plane, hand off to the queue
   // ---------------------------------------------------------------------
   bship_front #(
      .COORD_RANGE (COORD_RANGE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Decouple intake from iteration
   bship_queue #(
      .WIDTH ($bits(bship_pkg::job_type)),
      .DEPTH (bship_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_bits),
      .status    (queue_status)
   );

   assign pop_data = bship_pkg::job_type'(pop_bits);

   // ---------------------------------------------------------------------
   // Back end: iterate and hold the result until taken
   // ---------------------------------------------------------------------
   bship_engine #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .job          (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== sim/burning_ship_escape_time_core_tb.sv =====
// ----------------------------------------------------------------------------
// burning_ship_escape_time_core_tb - self-checking bench for the pixel core
// Drives pixel words with random gaps, stalls the result channel at random,
// predicts each escape count and color in Q4.28 fixed point and compares
// every result word field by field. Registers go through reset values,
// corner settings and random views of the plane, with read-back checks.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 12;
   localparam int FRAC        = bship_pkg::FRACTION_BITS_DEF;
   localparam int RANGE       = bship_pkg::COORD_RANGE_DEF;
   localparam int GAP_MAX     = 8;
   localparam int MAX_SHOWN   = 10;
   localparam int LONG_HOLD   = 3000;
   localparam int IDLE_PAUSE  = 8;
   localparam int TAIL_CYCLES = 40;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_ITEMS = 100;
   // The timeout allows roughly four times the slowest legal run (one
   // 65535-iteration pixel, 700 pixels at up to 120 iterations and 100 at up
   // to 400, full gaps, the long hold).
   localparam int TIMEOUT_NS  = 25_000_000;

   // Escape-time predictor plus the list of result words still awaited
   class escape_scoreboard;
      logic [bship_pkg::STEP_W-1:0]   step;
      int                             off_re;
      int                             off_im;
      logic [bship_pkg::LIMIT_W-1:0]  iter_limit;
      logic [bship_pkg::COLOUR_W-1:0] colour;
      bship_pkg::rsp_type             awaited_pixels[$];
      int unsigned                    faults;

      function new();
         step       = bship_pkg::RST_PIXEL_STEP;
         off_re     = bship_pkg::RST_OFFSET_REAL;
         off_im     = bship_pkg::RST_OFFSET_IMAG;
         iter_limit = bship_pkg::RST_LIMIT;
         colour     = bship_pkg::RST_COLOUR;
         faults     = 0;
      endfunction

      function void set_reg(bship_pkg::reg_index_type idx, logic [31:0] v);
         case (idx)
            bship_pkg::REG_PIXEL_STEP:  step = v[bship_pkg::STEP_W-1:0];
            bship_pkg::REG_OFFSET_REAL: off_re = v;
            bship_pkg::REG_OFFSET_IMAG: off_im = v;
            bship_pkg::REG_ITER_LIMIT:  iter_limit = v[bship_pkg::LIMIT_W-1:0];
            bship_pkg::REG_BASE_COLOUR: colour = v[bship_pkg::COLOUR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(bship_pkg::reg_index_type idx);
         case (idx)
            bship_pkg::REG_PIXEL_STEP:  return 32'(step);
            bship_pkg::REG_OFFSET_REAL: return off_re;
            bship_pkg::REG_OFFSET_IMAG: return off_im;
            bship_pkg::REG_ITER_LIMIT:  return 32'(iter_limit);
            bship_pkg::REG_BASE_COLOUR: return 32'(colour);
            default:                    return '0;
         endcase
      endfunction

      function longint clip_word(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function longint squared(longint v);
         longint unsigned m;
         m = magnitude(v);
         return longint'((m * m) >> FRAC);
      endfunction

      function bship_pkg::rsp_type escape_time(bship_pkg::req_type w);
         logic [bship_pkg::PIX_W-1:0] col;
         logic [bship_pkg::PIX_W-1:0] row;
         longint                      cr, ci, zr, zi, re, im;
         longint unsigned             cross_term, abs_re;
         int unsigned                 lim, count;
         logic [63:0]                 prod;
         bship_pkg::rsp_type          r;
         col = (w.pixel_col >= RANGE) ? bship_pkg::PIX_W'(RANGE - 1) : w.pixel_col;
         row = (w.pixel_row >= RANGE) ? bship_pkg::PIX_W'(RANGE - 1) : w.pixel_row;
         lim = (iter_limit == 0) ? 1 : iter_limit;
         cr  = clip_word(longint'(col) * longint'(step) + longint'(off_re));
         ci  = clip_word(longint'(row) * longint'(step) + longint'(off_im));
         zr = 0;
         zi = 0;
         count = 1;
         while (count < lim) begin
            re = clip_word(squared(zr) - squared(zi) + cr);
            cross_term = (magnitude(zr) * magnitude(zi)) >> (FRAC - 1);
            im = clip_word(longint'(cross_term) + ci);
            abs_re = magnitude(re);
            if (abs_re > 64'd2147483647) abs_re = 64'd2147483647;
            zr = longint'(abs_re);
            zi = im;
            if (squared(zr) + squared(zi) >= (longint'(4) << FRAC)) break;
            count++;
         end
         prod = 64'(colour) * 64'(count);
         r.out_col      = col;
         r.out_row      = row;
         r.escape_count = bship_pkg::LIMIT_W'(count);
         r.pixel_value  = (count == lim) ? bship_pkg::BLACK
                          : prod[bship_pkg::WORD_W-1:0];
         return r;
      endfunction

      function void note_pixel(bship_pkg::req_type w);
         awaited_pixels.push_back(escape_time(w));
      endfunction

      function void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
         if (faults < MAX_SHOWN)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
         faults++;
      endfunction

      function void check_result(bship_pkg::rsp_type got);
         bship_pkg::rsp_type want;
         if (awaited_pixels.size() == 0) begin
            note_mismatch("unrequested word, pixel value", 0, got.pixel_value);
            return;
         end
         want = awaited_pixels.pop_front();
         if (got.out_col != want.out_col)
            note_mismatch("out_col", want.out_col, got.out_col);
         if (got.out_row != want.out_row)
            note_mismatch("out_row", want.out_row, got.out_row);
         if (got.escape_count != want.escape_count)
            note_mismatch("escape_count", want.escape_count, got.escape_count);
         if (got.pixel_value != want.pixel_value)
            note_mismatch("pixel_value", want.pixel_value, got.pixel_value);
      endfunction

      function int awaited();
         return awaited_pixels.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   bship_pkg::req_type           req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   bship_pkg::rsp_type           rsp_data;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [bship_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]                  csr_pwdata;
   logic [31:0]                  csr_prdata;
   logic                         csr_pready;

   escape_scoreboard  sb;
   bit                req_gaps_on = 1'b1;
   bit                rsp_gaps_on = 1'b1;
   int unsigned       rsp_hold_cycles = 0;

   burning_ship_escape_time_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Offer one pixel word, optionally after a random gap, and hold it until
   // the core takes it. Returns at the falling edge after the handshake with
   // valid still high, so a following word goes out with no bubble.
   task automatic send_pixel(input int col, input int row);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel_col: bship_pkg::PIX_W'(col),
                     pixel_row: bship_pkg::PIX_W'(row)};
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_pixel(req_data);
      @(negedge clock);
   endtask

   // Drop valid and wait until every awaited result word has come back.
   // Always waits on the falling clock edge before checking, so valid is never
   // dropped and raised within one time step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.awaited() != 0);
   endtask

   // One register transfer: setup phase, then access phase until pready,
   // then a pause with psel low so back-to-back transfers never retoggle psel
   // within a single time step.
   task automatic csr_access(input logic wr, input bship_pkg::reg_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_write_reg(input bship_pkg::reg_index_type idx,
                                input logic [31:0] v);
      logic [31:0] ignored;
      csr_access(1'b1, idx, v, ignored);
      sb.set_reg(idx, v);
   endtask

   // Read every register back and compare with the predictor's copy
   task automatic csr_check_regs();
      bship_pkg::reg_index_type idx;
      logic [31:0]              got;
      idx = idx.first();
      do begin
         csr_access(1'b0, idx, '0, got);
         if (got !== sb.reg_value(idx))
            sb.note_mismatch({"register ", idx.name()}, sb.reg_value(idx), got);
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   // Reprogram the whole register set with the core idle. Every pixel yields
   // a result, so once the last one is back the engine is done; the short
   // pause only lets the output side settle.
   task automatic load_config(input logic [31:0] step_w, input logic [31:0] re_w,
                              input logic [31:0] im_w, input logic [31:0] lim_w,
                              input logic [31:0] colour_w);
      drain_results();
      repeat (IDLE_PAUSE) @(negedge clock);
      csr_write_reg(bship_pkg::REG_PIXEL_STEP, step_w);
      csr_write_reg(bship_pkg::REG_OFFSET_REAL, re_w);
      csr_write_reg(bship_pkg::REG_OFFSET_IMAG, im_w);
      csr_write_reg(bship_pkg::REG_ITER_LIMIT, lim_w);
      csr_write_reg(bship_pkg::REG_BASE_COLOUR, colour_w);
      csr_check_regs();
   endtask

   // Result side: draw a stall stretch per word (or the one long hold when
   // asked), then take the next word and check it.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         gap = rsp_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         sb.check_result(rsp_data);
         @(negedge clock);
      end
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [31:0] step_w, re_w, im_w, lim_w, colour_w;
      sb          = new();
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      reset       = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: read them back, then sample the default view at its
      // corners and a couple of interior points.
      csr_check_regs();
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(0, 1023);
      send_pixel(1023, 0);
      send_pixel(512, 600);
      send_pixel(700, 300);

      // Largest step, origin at the extreme corners: the imaginary part
      // saturates high for every pixel, so each escapes on the first pass;
      // the real part saturates at both ends. Upper bits beyond the step and
      // colour fields are set to check that they are dropped.
      load_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF,
                  32'hFFFF_FFFF);
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(1, 0);
      send_pixel(1023, 512);

      // Zero step maps every pixel onto the origin; c = 0 never escapes, so
      // this one pixel runs the full 65535-iteration limit.
      load_config(32'h0, 32'h0, 32'h0, 32'h0000_FFFF, 32'h0);
      send_pixel(1023, 1023);

      // Limit of one: no iteration, inside with count 1
      load_config(32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0012_3456);
      send_pixel(0, 0);
      send_pixel(1023, 1023);

      // Limit of zero must behave as one
      load_config(32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0012_3456);
      send_pixel(3, 4);
      send_pixel(1023, 0);

      // Limit of two with the default view: escape on the only iteration
      load_config(32'(bship_pkg::RST_PIXEL_STEP), bship_pkg::RST_OFFSET_REAL,
                  bship_pkg::RST_OFFSET_IMAG, 32'h2, 32'h1);
      send_pixel(0, 0);
      send_pixel(512, 512);

      // Random phases. Most are views of the ship itself, where counts spread
      // over the whole range; two are noise settings with random step and
      // origin. The last uses larger limits and full white so the colour
      // product wraps past 32 bits. Idling cycles through all four mixes.
      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == 3 || p == 6) begin
            step_w   = $urandom;
            re_w     = $urandom;
            im_w     = $urandom;
            colour_w = $urandom;
         end else begin
            step_w   = ($urandom & 32'h8000_0000)
                       | $urandom_range(32'h0001_0000, 32'h0010_0000);
            re_w     = 32'h0 - $urandom_range(32'h1000_0000, 32'h2800_0000);
            im_w     = 32'h0 - $urandom_range(32'h0800_0000, 32'h2800_0000);
            colour_w = (p == 7) ? 32'hFFFF_FFFF
                       : ($urandom & 32'hFF00_0000) | $urandom_range(0, 32'h00FF_FFFF);
         end
         lim_w = ($urandom & 32'hFFFF_0000)
                 | ((p == 7) ? $urandom_range(200, 400) : $urandom_range(2, 120));
         load_config(step_w, re_w, im_w, lim_w, colour_w);

         req_gaps_on = (p % 2 == 0);
         rsp_gaps_on = (p % 4 < 2);
         // Hold the result side off for a long stretch while pixels keep
         // coming back to back: the queue and output register fill and the
         // core has to stall its input.
         if (p == 5) begin
            req_gaps_on     = 1'b0;
            rsp_hold_cycles = LONG_HOLD;
         end

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Pause mid-phase until the core has handed back everything
            if (p == 1 && i == PHASE_ITEMS / 2)
               drain_results();
            send_pixel($urandom_range(0, RANGE - 1), $urandom_range(0, RANGE - 1));
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.faults == 0 && sb.awaited() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bship_pkg.sv
design/bship_front.sv
design/bship_queue.sv
design/bship_engine.sv
design/burning_ship_escape_time_core.sv
sim/burning_ship_escape_time_core_tb.sv
